// ----- sv/can_bit_timing_solver_core_defines.svh -----
// Assertion macros for the CAN bit timing solver checker.
`ifndef CAN_BIT_TIMING_SOLVER_CORE_DEFINES_SVH
`define CAN_BIT_TIMING_SOLVER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CBTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CBTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cbts_pkg.sv -----
// Shared constants, types and segment tables of the CAN bit timing solver.
`timescale 1ns / 1ps

package cbts_pkg;

    localparam logic [31:0] MIN_RATE  = 32'd1000;
    localparam logic [31:0] FAST_RATE = 32'd1000000;
    localparam logic [4:0]  SUM_FAST  = 5'd9;     // 10 quanta per bit
    localparam logic [4:0]  SUM_SLOW  = 5'd16;    // 17 quanta per bit
    localparam logic [4:0]  SUM_MIN   = 5'd2;
    localparam logic [10:0] PRE_MAX   = 11'd1024;
    localparam logic [3:0]  DIV_LAST  = 4'd15;    // 16 passes, two quotient bits each

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

    // Segment 1 for a segment sum, sample point near 87.5%, never above 90%.
    function automatic logic [4:0] seg_one_lut(input logic [4:0] sum);
        logic [4:0] s1;
        case (sum)
            5'd2:    s1 = 5'd1;
            5'd3:    s1 = 5'd2;
            5'd4:    s1 = 5'd3;
            5'd5:    s1 = 5'd4;
            5'd6:    s1 = 5'd5;
            5'd7:    s1 = 5'd6;
            5'd8:    s1 = 5'd7;
            5'd9:    s1 = 5'd8;
            5'd10:   s1 = 5'd8;
            5'd11:   s1 = 5'd9;
            5'd12:   s1 = 5'd10;
            5'd13:   s1 = 5'd11;
            5'd14:   s1 = 5'd12;
            5'd15:   s1 = 5'd13;
            5'd16:   s1 = 5'd14;
            default: s1 = 5'd0;
        endcase
        return s1;
    endfunction

    function automatic logic [3:0] seg_two_lut(input logic [4:0] sum);
        logic [3:0] s2;
        case (sum) inside
            [5'd2:5'd9]:   s2 = 4'd1;
            [5'd10:5'd11]: s2 = 4'd2;
            [5'd12:5'd16]: s2 = 4'd2;
            default:       s2 = 4'd0;
        endcase
        return s2;
    endfunction

endpackage

// ----- sv/cbts_req_if.sv -----
// Request channel: clock rate and wanted bit rate.
`timescale 1ns / 1ps

interface cbts_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] clock_hz;
    logic [31:0] target_bps;

    modport source (output valid, output clock_hz, output target_bps, input ready);
    modport sink   (input valid, input clock_hz, input target_bps, output ready);
endinterface

// ----- sv/cbts_res_if.sv -----
// Result channel: solved flag, prescaler and segments.
`timescale 1ns / 1ps

interface cbts_res_if;
    logic        valid;
    logic        ready;
    logic        solved;
    logic [10:0] prescale;
    logic        jump_width;
    logic [4:0]  seg_one;
    logic [3:0]  seg_two;

    modport source (output valid, output solved, output prescale, output jump_width,
                    output seg_one, output seg_two, input ready);
    modport sink   (input valid, input solved, input prescale, input jump_width,
                    input seg_one, input seg_two, output ready);
endinterface

// ----- sv/cbts_div.sv -----
// Shared 32-bit restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps

module cbts_div
    import cbts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [31:0] rem_step, quo_step;
    logic [32:0] trial;
    logic [32:0] diff;

    // quo_reg holds the remaining dividend bits on top and the quotient below
    always_comb
    begin
        rem_step = rem_reg;
        quo_step = quo_reg;
        trial    = '0;
        diff     = '0;
        for (int i = 0; i < 2; i++)
        begin
            trial    = {rem_step, quo_step[31]};
            quo_step = {quo_step[30:0], 1'b0};
            diff     = trial - {1'b0, dvs_reg};
            if (!diff[32])
            begin
                rem_step    = diff[31:0];
                quo_step[0] = 1'b1;
            end
            else
            begin
                rem_step = trial[31:0];
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            quo_next = quo_step;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- sv/can_bit_timing_solver_core.sv -----
// Top level of the CAN bit timing solver: sequencer around one shared divider.
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------
//   req     | in  | clock_hz[31:0], target_bps[31:0]
//   res     | out | solved, prescale[10:0], jump_width, seg_one[4:0], seg_two[3:0]
//
// Each division on the shared divider runs load, 16 passes, hand-off.
// A request runs clock/rate, one modulo trial per segment sum (1 to 15 trials), then
// one verify division (no verify on an early failure). A bit rate below 1000
// is answered without a division. req.ready is high only while idle. The result
// register holds a finished answer until taken; the next request may be
// accepted meanwhile. Reset (rst_n low, asynchronous) returns to idle.
`timescale 1ns / 1ps

module can_bit_timing_solver_core
    import cbts_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    cbts_req_if.sink       req,
    cbts_res_if.source     res
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PBS    = 5'b00010,
        ST_TRIAL  = 5'b00100,
        ST_VERIFY = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] clock_reg, clock_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] pbs_reg, pbs_next;
    logic [4:0]  sum_reg, sum_next;
    logic [10:0] pre_reg, pre_next;
    logic        ok_reg, ok_next;

    logic        start_reg, start_next;
    logic [31:0] dividend_reg, dividend_next;
    logic [31:0] divisor_reg, divisor_next;

    logic        res_valid_reg, res_valid_next;
    logic        solved_reg, solved_next;
    logic [10:0] prescale_reg, prescale_next;
    logic        jw_reg, jw_next;
    logic [4:0]  s1_reg, s1_next;
    logic [3:0]  s2_reg, s2_next;

    div_req_t    div_req;
    div_rsp_t    div_rsp;

    assign div_req.start    = start_reg;
    assign div_req.dividend = dividend_reg;
    assign div_req.divisor  = divisor_reg;

    cbts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        rate_next      = rate_reg;
        pbs_next       = pbs_reg;
        sum_next       = sum_reg;
        pre_next       = pre_reg;
        ok_next        = ok_reg;
        start_next     = 1'b0;
        dividend_next  = dividend_reg;
        divisor_next   = divisor_reg;
        res_valid_next = res_valid_reg;
        solved_next    = solved_reg;
        prescale_next  = prescale_reg;
        jw_next        = jw_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;

        if (res_valid_reg && res.ready)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    clock_next = req.clock_hz;
                    rate_next  = req.target_bps;
                    if (req.target_bps < MIN_RATE)
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        sum_next      = (req.target_bps >= FAST_RATE) ? SUM_FAST : SUM_SLOW;
                        start_next    = 1'b1;
                        dividend_next = req.clock_hz;
                        divisor_next  = req.target_bps;
                        state_next    = ST_PBS;
                    end
                end
            end
            ST_PBS:
            begin
                if (div_rsp.done)
                begin
                    pbs_next      = div_rsp.quotient;
                    start_next    = 1'b1;
                    dividend_next = div_rsp.quotient;
                    divisor_next  = {27'd0, sum_reg} + 32'd1;
                    state_next    = ST_TRIAL;
                end
            end
            ST_TRIAL:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == 32'd0)
                    begin
                        pre_next = div_rsp.quotient[10:0];
                        if (div_rsp.quotient == 32'd0 ||
                            div_rsp.quotient > {21'd0, PRE_MAX})
                        begin
                            ok_next    = 1'b0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            // pre * (1 + sum) is pbs, so the check is clock / pbs
                            start_next    = 1'b1;
                            dividend_next = clock_reg;
                            divisor_next  = pbs_reg;
                            state_next    = ST_VERIFY;
                        end
                    end
                    else if (sum_reg <= SUM_MIN)
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // new divisor 1 + (sum - 1) is the old sum
                        sum_next      = sum_reg - 5'd1;
                        start_next    = 1'b1;
                        dividend_next = pbs_reg;
                        divisor_next  = {27'd0, sum_reg};
                    end
                end
            end
            ST_VERIFY:
            begin
                if (div_rsp.done)
                begin
                    ok_next    = (div_rsp.quotient == rate_reg);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    solved_next    = ok_reg;
                    prescale_next  = ok_reg ? pre_reg : 11'd0;
                    jw_next        = ok_reg;
                    s1_next        = ok_reg ? seg_one_lut(sum_reg) : 5'd0;
                    s2_next        = ok_reg ? seg_two_lut(sum_reg) : 4'd0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clock_reg    <= clock_next;
        rate_reg     <= rate_next;
        pbs_reg      <= pbs_next;
        sum_reg      <= sum_next;
        pre_reg      <= pre_next;
        ok_reg       <= ok_next;
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        solved_reg   <= solved_next;
        prescale_reg <= prescale_next;
        jw_reg       <= jw_next;
        s1_reg       <= s1_next;
        s2_reg       <= s2_next;
    end

    assign res.valid      = res_valid_reg;
    assign res.solved     = solved_reg;
    assign res.prescale   = prescale_reg;
    assign res.jump_width = jw_reg;
    assign res.seg_one    = s1_reg;
    assign res.seg_two    = s2_reg;

endmodule

// ----- sv/cbts_checker.sv -----
// Port-level checker for the CAN bit timing solver, bound to the top level.
`timescale 1ns / 1ps
`include "can_bit_timing_solver_core_defines.svh"

module cbts_checker
    import cbts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic        solved,
    input logic [10:0] prescale,
    input logic        jump_width,
    input logic [4:0]  seg_one,
    input logic [3:0]  seg_two
);

    // stalled result must not change
    `CBTS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
        res_valid && $stable({solved, prescale, jump_width, seg_one, seg_two}),
        "stalled result changed")

    // one request at a time: busy right after an accept
    `CBTS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
        "request accepted while busy")

    `CBTS_ASSERT_NOW(a_solved_fields, res_valid && solved,
        jump_width && prescale != 11'd0 && prescale <= PRE_MAX &&
        seg_one != 5'd0 && seg_one <= 5'd16 && seg_two != 4'd0 && seg_two <= 4'd8,
        "solved result out of range")

    `CBTS_ASSERT_NOW(a_fail_zero, res_valid && !solved,
        !jump_width && prescale == 11'd0 && seg_one == 5'd0 && seg_two == 4'd0,
        "failed result not cleared")

endmodule

bind can_bit_timing_solver_core cbts_checker u_cbts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .solved     (res.solved),
    .prescale   (res.prescale),
    .jump_width (res.jump_width),
    .seg_one    (res.seg_one),
    .seg_two    (res.seg_two)
);

// ----- tb/sv/tb_can_bit_timing_solver_core.sv -----
// Self-checking testbench for the CAN bit timing solver: directed, random and backpressure runs.
`timescale 1ns / 1ps

module tb_can_bit_timing_solver_core;
    import cbts_pkg::*;

    localparam int          RESET_CYCLES = 8;
    localparam int          DRAIN_CYCLES = 400;      // outlasts the slowest request
    localparam int          LONG_HOLD    = 1500;
    localparam int unsigned SP_LIMIT     = 900;      // sample point ceiling, per mille
    localparam int unsigned PERMILLE     = 1000;
    localparam int unsigned SEG_ONE_MAX  = 16;
    localparam int unsigned SEG_TWO_MAX  = 8;

    typedef struct packed {
        logic        solved;
        logic [10:0] prescale;
        logic        jump_width;
        logic [4:0]  seg_one;
        logic [3:0]  seg_two;
    } bit_timing_t;

    typedef struct {
        logic [31:0] clock_hz;
        logic [31:0] target_bps;
        bit_timing_t timing;
    } pending_timing_t;

    logic clk;
    logic rst_n;

    cbts_req_if req_ch ();
    cbts_res_if res_ch ();

    can_bit_timing_solver_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .res   (res_ch.source)
    );

    pending_timing_t expected_timings[$];
    int              errors;
    int              requests_sent;
    int              results_seen;
    int              solved_seen;
    int              burst_left;
    bit              idle_on;
    int              ready_pct;
    int              hold_order;
    int              hold_left;
    int              hold_done;
    logic [15:0]     ready_pattern;
    int              pattern_pos;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout at %0t ns with %0d timings outstanding", $time,
                 expected_timings.size());
        $display("FAILURE");
        $finish;
    end

    // Expected timing, computed the same way the solver is specified.
    function automatic bit_timing_t solve_bit_timing(input logic [31:0] clock_hz,
                                                     input logic [31:0] target_bps);
        bit_timing_t timing;
        logic [31:0] per_bit;
        logic [31:0] sum;
        logic [31:0] pre;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] sample_pt;
        timing = '0;
        if (target_bps < MIN_RATE)
            return timing;
        sum     = (target_bps >= FAST_RATE) ? 32'(SUM_FAST) : 32'(SUM_SLOW);
        per_bit = clock_hz / target_bps;
        while ((per_bit % (sum + 32'd1)) != 32'd0)
        begin
            if (sum <= 32'(SUM_MIN))
                return timing;
            sum = sum - 32'd1;
        end
        pre = per_bit / (sum + 32'd1);
        if (pre < 32'd1 || pre > 32'(PRE_MAX))
            return timing;
        // nearest rounding first, round down if the sample point lands too late
        s1        = (32'd7 * sum + 32'd3) / 32'd8;
        s2        = sum - s1;
        sample_pt = (PERMILLE * (s1 + 32'd1)) / (sum + 32'd1);
        if (sample_pt > SP_LIMIT)
        begin
            s1 = (32'd7 * sum - 32'd1) / 32'd8;
            s2 = sum - s1;
        end
        if (s1 < 32'd1 || s1 > SEG_ONE_MAX || s2 < 32'd1 || s2 > SEG_TWO_MAX)
            return timing;
        if (target_bps != clock_hz / (pre * (32'd1 + s1 + s2)))
            return timing;
        timing.solved     = 1'b1;
        timing.prescale   = pre[10:0];
        timing.jump_width = 1'b1;
        timing.seg_one    = s1[4:0];
        timing.seg_two    = s2[3:0];
        return timing;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got, input pending_timing_t entry);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s wrong for clock %0d rate %0d: expected %0d, actual %0d",
                     $time, field, entry.clock_hz, entry.target_bps, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        pending_timing_t entry;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (expected_timings.size() == 0)
            begin
                errors++;
                $display("%0t ns: result with nothing expected: expected none, actual solved=%0b",
                         $time, res_ch.solved);
            end
            else
            begin
                entry = expected_timings.pop_front();
                if (entry.timing.solved)
                    solved_seen++;
                check_field("solved", 32'(entry.timing.solved), 32'(res_ch.solved), entry);
                check_field("prescale", 32'(entry.timing.prescale), 32'(res_ch.prescale),
                            entry);
                check_field("jump_width", 32'(entry.timing.jump_width),
                            32'(res_ch.jump_width), entry);
                check_field("seg_one", 32'(entry.timing.seg_one), 32'(res_ch.seg_one), entry);
                check_field("seg_two", 32'(entry.timing.seg_two), 32'(res_ch.seg_two), entry);
            end
        end
    end

    // Result side: long hold when ordered, otherwise a random ready pattern.
    always @(posedge clk)
    begin
        if (hold_order > 0)
        begin
            hold_left  = hold_order;
            hold_order = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            hold_done++;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (pattern_pos == 0)
                for (int i = 0; i < 16; i++)
                    ready_pattern[i] = ($urandom_range(0, 99) < ready_pct);
            res_ch.ready <= (ready_pct >= 100) || ready_pattern[pattern_pos];
            pattern_pos = (pattern_pos + 1) % 16;
        end
    end

    // Called right after a rising edge; returns at the edge that accepts the request.
    task automatic send_request(input logic [31:0] clock_hz, input logic [31:0] target_bps);
        int              gap;
        pending_timing_t entry;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = 0;
            if (idle_on)
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: gap = $urandom_range(0, 3);
                    5, 6, 7:       gap = $urandom_range(0, 40);
                    8:             gap = $urandom_range(60, 320);
                    default:       gap = 0;
                endcase
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid      <= 1'b1;
        req_ch.clock_hz   <= clock_hz;
        req_ch.target_bps <= target_bps;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        entry.clock_hz   = clock_hz;
        entry.target_bps = target_bps;
        entry.timing     = solve_bit_timing(clock_hz, target_bps);
        expected_timings.push_back(entry);
        burst_left--;
        requests_sent++;
    endtask

    task automatic stop_requests();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
    endtask

    // Clock built as rate * prescaler * quanta, now and then with a small offset.
    task automatic send_exact_timing();
        int unsigned       quanta;
        int unsigned       pre;
        int unsigned       top_rate;
        int unsigned       rate;
        longint unsigned   clock64;
        quanta = $urandom_range(3, 17);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: pre = $urandom_range(1, 16);
            7, 8:                pre = $urandom_range(1, 1024);
            default:             pre = $urandom_range(1000, 1100);
        endcase
        top_rate = 32'hFFFF_FFFF / (pre * quanta);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
                rate = $urandom_range(1000, (top_rate < 999_999) ? top_rate : 999_999);
            5, 6, 7, 8:
                if (top_rate >= 1_000_000)
                    rate = $urandom_range(1_000_000,
                                          (top_rate < 8_000_000) ? top_rate : 8_000_000);
                else
                    rate = $urandom_range(1000, top_rate);
            default:
                rate = $urandom_range(1000, top_rate);
        endcase
        clock64 = longint'(rate) * pre * quanta;
        if ($urandom_range(0, 6) == 0)
            clock64 = clock64 + $urandom_range(1, pre * quanta);
        if (clock64 > 64'h0000_0000_FFFF_FFFF)
            clock64 = 64'h0000_0000_FFFF_FFFF;
        send_request(clock64[31:0], rate);
    endtask

    task automatic send_noise_request();
        case ($urandom_range(0, 4))
            0:       send_request($urandom, $urandom);
            1:       send_request($urandom, $urandom_range(0, 2000));
            2:       send_request($urandom, $urandom_range(1000, 2_000_000));
            3:       send_request($urandom_range(0, 100_000), $urandom_range(0, 100_000));
            default: send_request($urandom >> $urandom_range(0, 31),
                                  $urandom >> $urandom_range(0, 31));
        endcase
    endtask

    task automatic test_directed_cases();
        logic [31:0] clocks[] = '{
            32'd80_000_000, 32'd80_000_000, 32'd0,          32'hFFFF_FFFF,
            32'd0,          32'd999,        32'hFFFF_FFFF,  32'd17_408_000,
            32'd17_425_000, 32'd11_000,     32'd17_017,     32'd19_000,
            32'd3_000,      32'd4_000,      32'd3_000_000,  32'hFFFF_FFFF,
            32'd36_000_000, 32'd4_000_000_000, 32'd16_999_983, 32'd48_000_000,
            32'd1_000,      32'hFFFF_FFFF};
        logic [31:0] rates[] = '{
            32'd500_000,    32'd1_000_000,  32'd0,          32'd999,
            32'd1_000,      32'd1_000,      32'hFFFF_FFFF,  32'd1_000,
            32'd1_000,      32'd1_000,      32'd1_000,      32'd1_000,
            32'd1_000,      32'd1_000,      32'd1_000_000,  32'd1_000,
            32'd1_000_000,  32'd1_000_000,  32'd999_999,    32'd125_000,
            32'd1_000,      32'h8000_0000};
        idle_on   = 1'b1;
        ready_pct = 70;
        foreach (clocks[i])
            send_request(clocks[i], rates[i]);
    endtask

    task automatic test_exact_timings(input int count);
        idle_on   = 1'b1;
        ready_pct = 75;
        repeat (count) send_exact_timing();
    endtask

    task automatic test_noise(input int count);
        idle_on   = 1'b1;
        ready_pct = 50;
        repeat (count) send_noise_request();
    endtask

    task automatic test_no_idle(input int count);
        idle_on   = 1'b0;
        ready_pct = 100;
        repeat (count)
            if ($urandom_range(0, 3) == 0)
                send_noise_request();
            else
                send_exact_timing();
    endtask

    // Result side held off while requests keep coming: the held result blocks the solver.
    task automatic test_backpressure(input int count);
        stop_requests();
        @(negedge clk);
        hold_order = LONG_HOLD;
        @(posedge clk);
        idle_on   = 1'b0;
        ready_pct = 60;
        repeat (count) send_exact_timing();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.clock_hz   = '0;
        req_ch.target_bps = '0;
        res_ch.ready      = 1'b0;
        errors            = 0;
        requests_sent     = 0;
        results_seen      = 0;
        solved_seen       = 0;
        burst_left        = 0;
        idle_on           = 1'b1;
        ready_pct         = 100;
        hold_order        = 0;
        hold_left         = 0;
        hold_done         = 0;
        ready_pattern     = '1;
        pattern_pos       = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_exact_timings(620);
        test_noise(230);
        test_backpressure(60);
        test_no_idle(120);

        stop_requests();
        ready_pct = 100;
        while (expected_timings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d solved, %0d rejected) with random gaps and stalls,",
                 requests_sent, solved_seen, results_seen - solved_seen);
        $display("including one result-side hold of %0d cycles; %0d mismatches.",
                 hold_done, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
